/* design/mlpd_pkg.sv */
// Shared types and constants for the monochrome pixel draw engine.
// Used by mlpd_front, mlpd_back and mono_lcd_pixel_draw_engine.
`timescale 1ns / 1ps
`default_nettype none

package mlpd_pkg;

  localparam int unsigned COORD_W     = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned ADDR_W      = 9;
  localparam int unsigned STORE_WORDS = 512;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // lower half of the panel sits eight words further on in the store
  localparam logic [ADDR_W-1:0] LOWER_HALF_OFFSET = 9'd8;
  localparam logic [WORD_W-1:0] LEFT_BIT_MASK     = 16'h8000;

  // request codes on req_type
  localparam logic [2:0] REQ_PIXEL = 3'd0;
  localparam logic [2:0] REQ_HLINE = 3'd1;
  localparam logic [2:0] REQ_VLINE = 3'd2;
  localparam logic [2:0] REQ_RECT  = 3'd3;
  localparam logic [2:0] REQ_FILL  = 3'd4;
  localparam logic [2:0] REQ_READ  = 3'd5;

  typedef enum logic [2:0] {
    CMD_PIXEL,
    CMD_HLINE,
    CMD_VLINE,
    CMD_RECT,
    CMD_FILL,
    CMD_READ,
    CMD_NOP
  } cmd_e;

  // decoded command; rectangle corners already sorted
  typedef struct packed {
    cmd_e               op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] len;   // line length, or rectangle height
    logic [COORD_W-1:0] wlen;  // rectangle width
    logic               color;
  } cmd_t;

  typedef struct packed {
    logic clearing;  // power-up clearing pass running
    logic take;      // back end takes the head command this cycle
  } back_stat_t;

endpackage

`default_nettype wire

/* design/mlpd_front.sv */
// Front end: accepts requests, decodes and sorts them, and holds them in a
// short command queue for the back end. Depends on mlpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlpd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [2:0]                    req_type_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  x_start_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  y_start_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  x_end_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  y_end_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  line_length_i,
  input  wire logic                          color_i,
  input  wire mlpd_pkg::back_stat_t          back_stat_i,
  output logic                               cmd_valid_o,
  output mlpd_pkg::cmd_t                     cmd_o
);

  mlpd_pkg::cmd_t                  dec_cmd;
  mlpd_pkg::cmd_t                  queue_q [mlpd_pkg::QUEUE_DEPTH];
  logic [mlpd_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [mlpd_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [mlpd_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                            full, push, pop;
  logic [mlpd_pkg::COORD_W-1:0]    xlo, xhi, ylo, yhi;

  assign full        = (cnt_q == mlpd_pkg::QCNT_W'(mlpd_pkg::QUEUE_DEPTH));
  assign busy_o      = full | back_stat_i.clearing;
  assign push        = start_i & ~busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = back_stat_i.take & cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  assign xlo = (x_start_i > x_end_i) ? x_end_i : x_start_i;
  assign xhi = (x_start_i > x_end_i) ? x_start_i : x_end_i;
  assign ylo = (y_start_i > y_end_i) ? y_end_i : y_start_i;
  assign yhi = (y_start_i > y_end_i) ? y_start_i : y_end_i;

  always_comb begin
    dec_cmd       = '0;
    dec_cmd.x0    = x_start_i;
    dec_cmd.y0    = y_start_i;
    dec_cmd.x1    = x_end_i;
    dec_cmd.y1    = y_end_i;
    dec_cmd.len   = line_length_i;
    dec_cmd.color = color_i;
    case (req_type_i)
      mlpd_pkg::REQ_PIXEL: dec_cmd.op = mlpd_pkg::CMD_PIXEL;
      mlpd_pkg::REQ_HLINE: dec_cmd.op = mlpd_pkg::CMD_HLINE;
      mlpd_pkg::REQ_VLINE: dec_cmd.op = mlpd_pkg::CMD_VLINE;
      mlpd_pkg::REQ_RECT: begin
        dec_cmd.op   = mlpd_pkg::CMD_RECT;
        dec_cmd.x0   = xlo;
        dec_cmd.x1   = xhi;
        dec_cmd.y0   = ylo;
        dec_cmd.y1   = yhi;
        // a full 0..255 span wraps to zero and draws nothing
        dec_cmd.len  = yhi - ylo + 8'd1;
        dec_cmd.wlen = xhi - xlo + 8'd1;
      end
      mlpd_pkg::REQ_FILL: dec_cmd.op = mlpd_pkg::CMD_FILL;
      mlpd_pkg::REQ_READ: dec_cmd.op = mlpd_pkg::CMD_READ;
      default:            dec_cmd.op = mlpd_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec_cmd;
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mlpd_pkg::QCNT_W'(mlpd_pkg::QUEUE_DEPTH))
    else $error("command queue overfilled");
`endif

endmodule

`default_nettype wire

/* design/mlpd_back.sv */
// Back end: sequencer that walks lines, rectangle sides, fills and reads
// over the 512x16 frame store (read-modify-write per pixel). Depends on mlpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlpd_back #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire mlpd_pkg::cmd_t                cmd_i,
  output mlpd_pkg::back_stat_t               back_stat_o,
  output logic                               done_o,
  output logic [mlpd_pkg::WORD_W-1:0]        word_data_o,
  output logic                               off_screen_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEG,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_FILL,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_e;

  localparam logic [mlpd_pkg::COORD_W:0] WIDTH_LIM  = (mlpd_pkg::COORD_W+1)'(SCREEN_WIDTH);
  localparam logic [mlpd_pkg::COORD_W:0] HEIGHT_LIM = (mlpd_pkg::COORD_W+1)'(SCREEN_HEIGHT);

  state_e                          state_q;
  mlpd_pkg::cmd_t                  cmd_q;
  logic [1:0]                      seg_q;
  logic [mlpd_pkg::ADDR_W-1:0]     cnt_q;
  logic [mlpd_pkg::COORD_W-1:0]    bx_q, by_q, blen_q;
  logic                            bhoriz_q;
  logic                            done_q, off_q;
  logic [mlpd_pkg::WORD_W-1:0]     data_q;

  logic [mlpd_pkg::WORD_W-1:0]     store_q [mlpd_pkg::STORE_WORDS];
  logic [mlpd_pkg::WORD_W-1:0]     rd_q;
  logic                            we;
  logic [mlpd_pkg::ADDR_W-1:0]     wa;
  logic [mlpd_pkg::WORD_W-1:0]     wd;

  logic [mlpd_pkg::COORD_W-1:0]    px, py;
  logic                            on_scr;
  logic [mlpd_pkg::ADDR_W-1:0]     pix_addr;
  logic [mlpd_pkg::WORD_W-1:0]     pix_mask, pix_word;
  logic                            last_seg, seg_end;

  assign px = bhoriz_q ? bx_q + cnt_q[mlpd_pkg::COORD_W-1:0] : bx_q;
  assign py = bhoriz_q ? by_q : by_q + cnt_q[mlpd_pkg::COORD_W-1:0];

  assign on_scr = ({1'b0, px} < WIDTH_LIM) && ({1'b0, py} < HEIGHT_LIM);

  // split-page layout: 16 words per row, lower half offset by eight words
  assign pix_addr = {py[4:0], px[7:4]}
                  + ((py[7:5] != 3'd0) ? mlpd_pkg::LOWER_HALF_OFFSET : '0);
  assign pix_mask = mlpd_pkg::LEFT_BIT_MASK >> px[3:0];
  assign pix_word = cmd_q.color ? (rd_q | pix_mask) : (rd_q & ~pix_mask);

  assign last_seg = (cmd_q.op != mlpd_pkg::CMD_RECT) || (seg_q == 2'd3);
  assign seg_end  = (cnt_q[mlpd_pkg::COORD_W-1:0] == blen_q);

  assign back_stat_o.clearing = (state_q == ST_CLEAR);
  assign back_stat_o.take     = (state_q == ST_IDLE) && cmd_valid_i;

  assign done_o       = done_q;
  assign word_data_o  = data_q;
  assign off_screen_o = off_q;

  always_comb begin
    we = 1'b0;
    wa = pix_addr;
    wd = pix_word;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        wa = cnt_q;
        wd = '0;
      end
      ST_FILL: begin
        we = 1'b1;
        wa = cnt_q;
        wd = {mlpd_pkg::WORD_W{cmd_q.color}};
      end
      ST_PIX_WR: we = 1'b1;
      default:   we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[wa] <= wd;
    end
    rd_q <= store_q[pix_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cmd_q    <= '0;
      seg_q    <= '0;
      cnt_q    <= '0;
      bx_q     <= '0;
      by_q     <= '0;
      blen_q   <= '0;
      bhoriz_q <= 1'b0;
      done_q   <= 1'b0;
      off_q    <= 1'b0;
      data_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (&cnt_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            seg_q    <= '0;
            cnt_q    <= '0;
            bx_q     <= cmd_i.x0;
            by_q     <= cmd_i.y0;
            bhoriz_q <= 1'b1;
            case (cmd_i.op)
              mlpd_pkg::CMD_PIXEL, mlpd_pkg::CMD_HLINE, mlpd_pkg::CMD_VLINE,
              mlpd_pkg::CMD_RECT: state_q <= ST_SEG;
              mlpd_pkg::CMD_FILL: state_q <= ST_FILL;
              mlpd_pkg::CMD_READ: state_q <= ST_RD_ADDR;
              default: begin
                done_q <= 1'b1;
                data_q <= '0;
                off_q  <= 1'b0;
              end
            endcase
          end
        end
        ST_SEG: begin
          cnt_q    <= '0;
          bx_q     <= cmd_q.x0;
          by_q     <= cmd_q.y0;
          blen_q   <= cmd_q.len;
          bhoriz_q <= 1'b1;
          case (cmd_q.op)
            mlpd_pkg::CMD_PIXEL: blen_q <= 8'd1;
            mlpd_pkg::CMD_VLINE: bhoriz_q <= 1'b0;
            mlpd_pkg::CMD_RECT: begin
              // left, right, top, bottom
              case (seg_q)
                2'd0: bhoriz_q <= 1'b0;
                2'd1: begin
                  bx_q     <= cmd_q.x1;
                  bhoriz_q <= 1'b0;
                end
                2'd2: blen_q <= cmd_q.wlen;
                default: begin
                  by_q   <= cmd_q.y1;
                  blen_q <= cmd_q.wlen;
                end
              endcase
            end
            default: bhoriz_q <= 1'b1;
          endcase
          state_q <= ST_PIX_RD;
        end
        ST_PIX_RD: begin
          if (seg_end) begin
            if (last_seg) begin
              done_q  <= 1'b1;
              data_q  <= '0;
              // a lone pixel reports whether it fell off the panel
              off_q   <= (cmd_q.op == mlpd_pkg::CMD_PIXEL) &&
                         !(({1'b0, cmd_q.x0} < WIDTH_LIM) &&
                           ({1'b0, cmd_q.y0} < HEIGHT_LIM));
              state_q <= ST_IDLE;
            end else begin
              seg_q   <= seg_q + 1'b1;
              state_q <= ST_SEG;
            end
          end else if (on_scr) begin
            state_q <= ST_PIX_WR;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_PIX_WR: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= ST_PIX_RD;
        end
        ST_FILL: begin
          cnt_q <= cnt_q + 1'b1;
          if (&cnt_q) begin
            done_q  <= 1'b1;
            data_q  <= '0;
            off_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        ST_RD_ADDR: begin
          if (on_scr) begin
            state_q <= ST_RD_DATA;
          end else begin
            done_q  <= 1'b1;
            data_q  <= '0;
            off_q   <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_RD_DATA: begin
          done_q  <= 1'b1;
          data_q  <= rd_q;
          off_q   <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !we)
    else $error("store written while idle");

  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX_WR) |-> ($past(state_q) == ST_PIX_RD))
    else $error("pixel write without preceding read");

  a_off_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && off_q |-> (data_q == '0))
    else $error("off-screen beat carries data");

  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !done_q)
    else $error("result during clearing pass");
`endif

endmodule

`default_nettype wire

/* design/mono_lcd_pixel_draw_engine.sv */
// Top level of the monochrome pixel draw engine: front end with command
// queue, back end sequencer with the frame store. Depends on mlpd_pkg.
//
//  channel   direction  handshake             ports
//  request   in         start_i & !busy_o     req_type_i .. color_i
//  result    out        done_o, one cycle     word_data_o, off_screen_o
//
// After reset the store is cleared word by word with busy_o high.
// The sequencer takes one beat at a time from the queue; each on-screen pixel
// of a pixel, line or rectangle is read, modified and written back through
// the store's single read-modify-write port, while a fill writes whole words.
// A two-entry queue takes requests while the sequencer works, busy_o high
// when full; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module mono_lcd_pixel_draw_engine #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [2:0]                    req_type_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  x_start_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  y_start_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  x_end_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  y_end_i,
  input  wire logic [mlpd_pkg::COORD_W-1:0]  line_length_i,
  input  wire logic                          color_i,
  output logic                               done_o,
  output logic [mlpd_pkg::WORD_W-1:0]        word_data_o,
  output logic                               off_screen_o
);

  mlpd_pkg::back_stat_t back_stat;
  mlpd_pkg::cmd_t       cmd;
  logic                 cmd_valid;

  mlpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .line_length_i (line_length_i),
    .color_i       (color_i),
    .back_stat_i   (back_stat),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  mlpd_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .back_stat_o  (back_stat),
    .done_o       (done_o),
    .word_data_o  (word_data_o),
    .off_screen_o (off_screen_o)
  );

endmodule

`default_nettype wire

/* tb/mono_lcd_pixel_draw_engine_test.sv */
// Self-checking testbench for mono_lcd_pixel_draw_engine: drives draw and read
// requests, mirrors the frame store and checks every result beat in order.
// Depends on mlpd_pkg and the engine RTL only.
`timescale 1ns / 1ps

module mono_lcd_pixel_draw_engine_test;
  import mlpd_pkg::*;

  localparam int unsigned PANEL_W    = 128;
  localparam int unsigned PANEL_H    = 64;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned TAIL_WAIT  = 64;
  localparam int unsigned RAND_ITEMS = 600;
  localparam int unsigned MAX_SHOWN  = 10;

  // codes the engine must ignore
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              off;
  } pix_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start_i       = 1'b0;
  logic [2:0]         req_type_i    = REQ_PIXEL;
  logic [COORD_W-1:0] x_start_i     = '0;
  logic [COORD_W-1:0] y_start_i     = '0;
  logic [COORD_W-1:0] x_end_i       = '0;
  logic [COORD_W-1:0] y_end_i       = '0;
  logic [COORD_W-1:0] line_length_i = '0;
  logic               color_i       = 1'b0;
  logic               busy_o;
  logic               done_o;
  logic [WORD_W-1:0]  word_data_o;
  logic               off_screen_o;

  logic [WORD_W-1:0]  panel_words [STORE_WORDS];
  pix_result_t        readback_q [$];
  int unsigned        mismatch_count = 0;
  int unsigned        stall_cycles = 0;
  bit                 idle_en = 1'b1;

  mono_lcd_pixel_draw_engine #(
    .SCREEN_WIDTH (PANEL_W),
    .SCREEN_HEIGHT(PANEL_H)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .line_length_i(line_length_i),
    .color_i      (color_i),
    .done_o       (done_o),
    .word_data_o  (word_data_o),
    .off_screen_o (off_screen_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic bit on_panel(logic [7:0] x, logic [7:0] y);
    return (x < PANEL_W) && (y < PANEL_H);
  endfunction

  // split-page layout: lower half of the panel is offset by eight words
  function automatic logic [ADDR_W-1:0] word_addr(logic [7:0] x, logic [7:0] y);
    int a;
    a = (y % 32) * 16 + x / 16;
    if (y >= 32) a += 8;
    return ADDR_W'(a);
  endfunction

  function automatic void plot_pixel(logic [7:0] x, logic [7:0] y, logic c);
    logic [ADDR_W-1:0] a;
    logic [3:0]        b;
    if (!on_panel(x, y)) return;
    a = word_addr(x, y);
    b = 4'd15 - x[3:0];
    panel_words[a][b] = c;
  endfunction

  function automatic void draw_hline(logic [7:0] x, logic [7:0] y, logic [7:0] len,
                                     logic c);
    for (int i = 0; i < len; i++) plot_pixel(8'(x + i), y, c);
  endfunction

  function automatic void draw_vline(logic [7:0] x, logic [7:0] y, logic [7:0] len,
                                     logic c);
    for (int i = 0; i < len; i++) plot_pixel(x, 8'(y + i), c);
  endfunction

  function automatic pix_result_t apply_request(logic [2:0] req, logic [7:0] xs,
                                                logic [7:0] ys, logic [7:0] xe,
                                                logic [7:0] ye, logic [7:0] len,
                                                logic c);
    pix_result_t r;
    logic [7:0]  lo_x, hi_x, lo_y, hi_y, w, h;
    r.word = '0;
    r.off  = 1'b0;
    case (req)
      REQ_PIXEL: begin
        r.off = !on_panel(xs, ys);
        plot_pixel(xs, ys, c);
      end
      REQ_HLINE: draw_hline(xs, ys, len, c);
      REQ_VLINE: draw_vline(xs, ys, len, c);
      REQ_RECT: begin
        lo_x = (xs > xe) ? xe : xs;
        hi_x = (xs > xe) ? xs : xe;
        lo_y = (ys > ye) ? ye : ys;
        hi_y = (ys > ye) ? ys : ye;
        // full 0..255 span wraps to zero length
        h = hi_y - lo_y + 8'd1;
        w = hi_x - lo_x + 8'd1;
        draw_vline(lo_x, lo_y, h, c);
        draw_vline(hi_x, lo_y, h, c);
        draw_hline(lo_x, lo_y, w, c);
        draw_hline(lo_x, hi_y, w, c);
      end
      REQ_FILL: foreach (panel_words[i]) panel_words[i] = {WORD_W{c}};
      REQ_READ: begin
        if (on_panel(xs, ys)) r.word = panel_words[word_addr(xs, ys)];
        else                  r.off  = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ----------------------------------------------------------------- checking
  task automatic note_mismatch(string what, int unsigned exp_v, int unsigned act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    pix_result_t e;
    if (rst_ni && done_o) begin
      if (readback_q.size() == 0) begin
        note_mismatch("unexpected result beat", 0, word_data_o);
      end else begin
        e = readback_q.pop_front();
        if (word_data_o !== e.word) note_mismatch("word_data", e.word, word_data_o);
        if (off_screen_o !== e.off) note_mismatch("off_screen", e.off, off_screen_o);
      end
    end
  end

  // no beat either way for too long means the engine has hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
      else                                 stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("FAIL mono_lcd_pixel_draw_engine");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------ driving
  task automatic send_req(logic [2:0] req, logic [7:0] xs, logic [7:0] ys,
                          logic [7:0] xe, logic [7:0] ye, logic [7:0] len, logic c);
    while (idle_en && ($urandom_range(99) < 17)) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    req_type_i    <= req;
    x_start_i     <= xs;
    y_start_i     <= ys;
    x_end_i       <= xe;
    y_end_i       <= ye;
    line_length_i <= len;
    color_i       <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    readback_q.push_back(apply_request(req, xs, ys, xe, ye, len, c));
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (readback_q.size() != 0);
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_pixels();
    send_req(REQ_PIXEL, 8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 1'b1);
    send_req(REQ_PIXEL, 8'd127, 8'd63,  8'd0, 8'd0, 8'd0, 1'b1);
    send_req(REQ_PIXEL, 8'd128, 8'd5,   8'd0, 8'd0, 8'd0, 1'b1);
    send_req(REQ_PIXEL, 8'd5,   8'd64,  8'd0, 8'd0, 8'd0, 1'b1);
    send_req(REQ_PIXEL, 8'd255, 8'd255, 8'hff, 8'hff, 8'hff, 1'b0);
    send_req(REQ_READ,  8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 1'b0);
    send_req(REQ_READ,  8'd127, 8'd63,  8'd0, 8'd0, 8'd0, 1'b0);
  endtask

  task automatic test_lines();
    send_req(REQ_HLINE, 8'd120, 8'd10,  8'd0, 8'd0, 8'd20,  1'b1);  // runs off the right
    send_req(REQ_VLINE, 8'd7,   8'd250, 8'd0, 8'd0, 8'd20,  1'b1);  // wraps past 255
    send_req(REQ_HLINE, 8'd250, 8'd33,  8'd0, 8'd0, 8'd255, 1'b1);  // wraps round to x 0
    send_req(REQ_VLINE, 8'd3,   8'd3,   8'd0, 8'd0, 8'd0,   1'b1);  // zero length
    send_req(REQ_READ,  8'd0,   8'd33,  8'd0, 8'd0, 8'd0,   1'b0);
    send_req(REQ_READ,  8'd7,   8'd2,   8'd0, 8'd0, 8'd0,   1'b0);
  endtask

  task automatic test_rects();
    send_req(REQ_RECT, 8'd100, 8'd40,  8'd20,  8'd5,   8'd0, 1'b0);  // corners reversed
    send_req(REQ_RECT, 8'd0,   8'd0,   8'd255, 8'd255, 8'd0, 1'b1);  // full span, no sides
    send_req(REQ_READ, 8'd20,  8'd5,   8'd0,   8'd0,   8'd0, 1'b0);
  endtask

  task automatic test_fill_and_read();
    send_req(REQ_FILL,    8'd0,   8'd0,  8'd0, 8'd0, 8'd0, 1'b1);
    send_req(REQ_READ,    8'd64,  8'd40, 8'd0, 8'd0, 8'd0, 1'b0);
    send_req(REQ_FILL,    8'd0,   8'd0,  8'd0, 8'd0, 8'd0, 1'b0);
    send_req(REQ_READ,    8'd200, 8'd10, 8'd0, 8'd0, 8'd0, 1'b0);
    send_req(REQ_SPARE_6, 8'd1,   8'd1,  8'd1, 8'd1, 8'd1, 1'b1);
    send_req(REQ_SPARE_7, 8'd2,   8'd2,  8'd2, 8'd2, 8'd2, 1'b1);
  endtask

  function automatic logic [7:0] rand_coord(int unsigned span);
    if ($urandom_range(99) < 20) return 8'($urandom_range(255));
    return 8'($urandom_range(span));
  endfunction

  task automatic test_random();
    logic [2:0] req;
    logic [7:0] xs, ys, xe, ye, len;
    int unsigned pick;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_en = !(n >= 200 && n < 350);
      if (n == 400) drain_results();
      pick = $urandom_range(99);
      if      (pick < 30) req = REQ_READ;
      else if (pick < 50) req = REQ_PIXEL;
      else if (pick < 65) req = REQ_HLINE;
      else if (pick < 80) req = REQ_VLINE;
      else if (pick < 92) req = REQ_RECT;
      else if (pick < 95) req = REQ_FILL;
      else                req = ($urandom_range(1) != 0) ? REQ_SPARE_6 : REQ_SPARE_7;
      xs  = rand_coord(PANEL_W + 12);
      ys  = rand_coord(PANEL_H + 8);
      xe  = rand_coord(PANEL_W + 12);
      ye  = rand_coord(PANEL_H + 8);
      len = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
      send_req(req, xs, ys, xe, ye, len, 1'($urandom_range(1)));
    end
    idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------- main
  initial begin
    foreach (panel_words[i]) panel_words[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pixels();
    test_lines();
    test_rects();
    test_fill_and_read();
    test_random();
    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (readback_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("PASS mono_lcd_pixel_draw_engine");
    end else begin
      $display("FAIL mono_lcd_pixel_draw_engine");
    end
    $finish;
  end

endmodule
